// ----- rtl/ipa_pkg.sv -----
`default_nettype none

package ipa_pkg;

	// conversion kind codes
	localparam logic [1:0] FUNC_SDEC = 2'd0;
	localparam logic [1:0] FUNC_UDEC = 2'd1;
	localparam logic [1:0] FUNC_HEX  = 2'd2;
	// spare code, formats as unsigned decimal
	localparam logic [1:0] FUNC_RSVD = 2'd3;

	// widest pad request that is honored
	localparam logic [3:0] PAD_MAX = 4'd9;

	// ASCII characters used by the formatter
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_A_LOW = 8'h61;

	// per-item formatting controls, resolved by the front end
	typedef struct packed {
		logic       neg;
		logic       is_hex;
		logic [3:0] pad;
		logic       zero_pad;
	} fmt_t;

endpackage

`default_nettype wire

// ----- rtl/ipa_front.sv -----
`default_nettype none

module ipa_front #(
	parameter int WORD_BITS = 32
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic [31:0]          value,
	input  wire logic [1:0]           func,
	input  wire logic [3:0]           pad_width,
	input  wire logic                 zero_pad,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic [WORD_BITS-1:0]      out_mag,
	output ipa_pkg::fmt_t             out_fmt
);

	logic [WORD_BITS-1:0]  word;
	logic [WORD_BITS-1:0]  mag;
	ipa_pkg::fmt_t         fmt;
	logic                  vld_s1;
	logic [WORD_BITS-1:0]  mag_s1;
	ipa_pkg::fmt_t         fmt_s1;

	// fit the input word to WORD_BITS (truncate or zero-extend)
	assign word = WORD_BITS'(value);

	// classify: sign, magnitude, radix, saturated pad width
	always_comb begin
		fmt.neg      = (func == ipa_pkg::FUNC_SDEC) && word[WORD_BITS-1];
		fmt.is_hex   = (func == ipa_pkg::FUNC_HEX);
		fmt.pad      = (pad_width > ipa_pkg::PAD_MAX) ? ipa_pkg::PAD_MAX : pad_width;
		fmt.zero_pad = zero_pad;
		mag          = fmt.neg ? (~word + {{(WORD_BITS-1){1'b0}}, 1'b1}) : word;
	end

	assign in_ready = !vld_s1 || out_ready;

	// holding stage toward the queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			mag_s1 <= mag;
			fmt_s1 <= fmt;
		end
	end

	assign out_valid = vld_s1;
	assign out_mag   = mag_s1;
	assign out_fmt   = fmt_s1;

endmodule

`default_nettype wire

// ----- rtl/ipa_queue.sv -----
`default_nettype none

module ipa_queue #(
	parameter int DW = 8
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire logic [DW-1:0] in_data,
	output logic               out_valid,
	input  wire logic          out_ready,
	output logic [DW-1:0]      out_data
);

	logic [DW-1:0] buf_q [2];
	logic          wptr_q;
	logic          rptr_q;
	logic [1:0]    cnt_q;
	logic          push;
	logic          pop;

	assign in_ready  = (cnt_q != 2'd2);
	assign out_valid = (cnt_q != 2'd0);
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;
	assign out_data  = buf_q[rptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (push) wptr_q <= ~wptr_q;
			if (pop)  rptr_q <= ~rptr_q;
			if (push && !pop)      cnt_q <= cnt_q + 2'd1;
			else if (pop && !push) cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wptr_q] <= in_data;
		end
	end

	// fill count never exceeds the two entries
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("queue fill count out of range");

endmodule

`default_nettype wire

// ----- rtl/ipa_back.sv -----
`default_nettype none

module ipa_back #(
	parameter int WORD_BITS = 32
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic [WORD_BITS-1:0] in_mag,
	input  wire ipa_pkg::fmt_t        in_fmt,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic [7:0]                out_char,
	output logic                      last
);

	localparam int NDIG  = (WORD_BITS * 30103) / 100000 + 1;
	localparam int BCD_W = 4 * NDIG;
	localparam int CNT_W = $clog2(WORD_BITS + 1);
	localparam int DIG_W = $clog2(NDIG + 1);
	localparam int LEN_W = ((DIG_W > 4) ? DIG_W : 4) + 1;

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_CONV  = 6'b000010,
		ST_TRIM  = 6'b000100,
		ST_PAD   = 6'b001000,
		ST_SIGN  = 6'b010000,
		ST_DIGIT = 6'b100000
	} state_t;

	state_t                 state_q;
	logic [BCD_W-1:0]       bcd_q;
	logic [WORD_BITS-1:0]   sh_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [DIG_W-1:0]       ndig_q;
	logic [3:0]             npad_q;
	ipa_pkg::fmt_t          fmt_q;
	logic [7:0]             char_q;
	logic                   last_q;
	logic                   ovld_q;

	logic [BCD_W-1:0]       adj;
	logic [3:0]             top_nib;
	logic [7:0]             dig_char;
	logic [LEN_W-1:0]       len;
	logic [LEN_W-1:0]       padw;
	logic                   out_free;
	logic                   emit;

	// add-3 correction on every BCD digit before the shift
	always_comb begin
		for (int i = 0; i < NDIG; i++) begin
			adj[4*i +: 4] = (bcd_q[4*i +: 4] >= 4'd5) ? bcd_q[4*i +: 4] + 4'd3
								  : bcd_q[4*i +: 4];
		end
	end

	assign top_nib  = bcd_q[BCD_W-1 -: 4];
	assign dig_char = (top_nib < 4'd10) ? ipa_pkg::CH_ZERO + {4'b0, top_nib}
					    : ipa_pkg::CH_A_LOW + {4'b0, top_nib} - 8'd10;

	// text length including sign, against the pad width
	assign len  = LEN_W'(ndig_q) + LEN_W'(fmt_q.neg);
	assign padw = LEN_W'(fmt_q.pad);

	assign in_ready = (state_q == ST_IDLE);
	assign out_free = !ovld_q || out_ready;
	assign emit     = out_free && (((state_q == ST_PAD) && (npad_q != 4'd0)) ||
				 (state_q == ST_SIGN) || (state_q == ST_DIGIT));

	// conversion and character sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ovld_q  <= 1'b0;
		end else begin
			if (emit) ovld_q <= 1'b1;
			else if (out_ready) ovld_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_valid) state_q <= in_fmt.is_hex ? ST_TRIM : ST_CONV;
				end
				ST_CONV: begin
					if (cnt_q == CNT_W'(1)) state_q <= ST_TRIM;
				end
				ST_TRIM: begin
					if (!((top_nib == 4'd0) && (ndig_q != DIG_W'(1)))) state_q <= ST_PAD;
				end
				ST_PAD: begin
					if (npad_q == 4'd0) state_q <= fmt_q.neg ? ST_SIGN : ST_DIGIT;
				end
				ST_SIGN: begin
					if (emit) state_q <= ST_DIGIT;
				end
				ST_DIGIT: begin
					if (emit && (ndig_q == DIG_W'(1))) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					fmt_q  <= in_fmt;
					sh_q   <= in_mag;
					cnt_q  <= CNT_W'(WORD_BITS);
					ndig_q <= DIG_W'(NDIG);
					bcd_q  <= in_fmt.is_hex ? {{(BCD_W-WORD_BITS){1'b0}}, in_mag}
								: '0;
				end
			end
			ST_CONV: begin
				bcd_q <= {adj[BCD_W-2:0], sh_q[WORD_BITS-1]};
				sh_q  <= {sh_q[WORD_BITS-2:0], 1'b0};
				cnt_q <= cnt_q - CNT_W'(1);
			end
			ST_TRIM: begin
				// drop leading zero digits, keeping at least one
				if ((top_nib == 4'd0) && (ndig_q != DIG_W'(1))) begin
					bcd_q  <= {bcd_q[BCD_W-5:0], 4'd0};
					ndig_q <= ndig_q - DIG_W'(1);
				end else begin
					npad_q <= (padw > len) ? 4'(padw - len) : 4'd0;
				end
			end
			ST_PAD: begin
				if (emit) begin
					char_q <= fmt_q.zero_pad ? ipa_pkg::CH_ZERO : ipa_pkg::CH_SPACE;
					last_q <= 1'b0;
					npad_q <= npad_q - 4'd1;
				end
			end
			ST_SIGN: begin
				if (emit) begin
					char_q <= ipa_pkg::CH_MINUS;
					last_q <= 1'b0;
				end
			end
			ST_DIGIT: begin
				if (emit) begin
					char_q <= dig_char;
					last_q <= (ndig_q == DIG_W'(1));
					bcd_q  <= {bcd_q[BCD_W-5:0], 4'd0};
					ndig_q <= ndig_q - DIG_W'(1);
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid = ovld_q;
	assign out_char  = char_q;
	assign last      = last_q;

	// a busy item always has at least one digit left
	a_ndig_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_TRIM || state_q == ST_PAD || state_q == ST_SIGN ||
		 state_q == ST_DIGIT) |-> (ndig_q != '0))
		else $error("digit count reached zero while busy");

	// decimal conversion yields only decimal digits
	a_dec_digit: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && state_q == ST_DIGIT && !fmt_q.is_hex) |-> (top_nib < 4'd10))
		else $error("non-decimal digit in decimal output");

	// the last character frees the sequencer for the next item
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && state_q == ST_DIGIT && ndig_q == DIG_W'(1)) |=>
		(state_q == ST_IDLE && last_q))
		else $error("sequencer not idle after last character");

endmodule

`default_nettype wire

// ----- rtl/integer_to_padded_ascii.sv -----
// Integer to padded ASCII formatter.
//
// Input channel (in_valid/in_ready): one item is a 32-bit value, a conversion
// kind func (0 signed decimal, 1 or 3 unsigned decimal, 2 lowercase hex), a
// pad_width (values above 9 act as 9) and zero_pad. Output channel
// (out_valid/out_ready): one character per item accepted there, most
// significant first; pad characters come before the sign, last marks the
// final character of each input item.
// Sequence: the front stage and the queue each register the item, then the
// back end loads it; decimal items pass through the double-dabble
// conversion (hex skips it), leading zero digits are then removed one by
// one, the pad count is settled, and the pad characters, the sign and the
// digits are sent in turn.
// Occupancy: the back end holds one item at a time and takes no new item
// until the last character of the current one is emitted; its pace is set
// by the shared shift-and-add-3 converter and the one-character output
// register. The front stage and two-entry queue take up to three more items
// meanwhile.
// Reset clears all valid flags and returns the sequencer to idle. When the
// receiver stalls, the current character is held and the sequencer waits;
// the input side keeps accepting until the front stage and queue are full.
`default_nettype none

module integer_to_padded_ascii #(
	parameter int WORD_BITS = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [31:0] value,
	input  wire logic [1:0]  func,
	input  wire logic [3:0]  pad_width,
	input  wire logic        zero_pad,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [7:0]       out_char,
	output logic             last
);

	localparam int QW = WORD_BITS + $bits(ipa_pkg::fmt_t);

	logic                 f_valid;
	logic                 f_ready;
	logic [WORD_BITS-1:0] f_mag;
	ipa_pkg::fmt_t        f_fmt;
	logic                 q_valid;
	logic                 q_ready;
	logic [QW-1:0]        q_data;
	logic [WORD_BITS-1:0] b_mag;
	ipa_pkg::fmt_t        b_fmt;

	// classify incoming items
	ipa_front #(.WORD_BITS(WORD_BITS)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.value     (value),
		.func      (func),
		.pad_width (pad_width),
		.zero_pad  (zero_pad),
		.out_valid (f_valid),
		.out_ready (f_ready),
		.out_mag   (f_mag),
		.out_fmt   (f_fmt)
	);

	// decoupling queue between front and back
	ipa_queue #(.DW(QW)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (f_valid),
		.in_ready  (f_ready),
		.in_data   ({f_mag, f_fmt}),
		.out_valid (q_valid),
		.out_ready (q_ready),
		.out_data  (q_data)
	);

	assign b_mag = q_data[QW-1 -: WORD_BITS];
	assign b_fmt = q_data[$bits(ipa_pkg::fmt_t)-1:0];

	// convert and emit characters
	ipa_back #(.WORD_BITS(WORD_BITS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (q_valid),
		.in_ready  (q_ready),
		.in_mag    (b_mag),
		.in_fmt    (b_fmt),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_char  (out_char),
		.last      (last)
	);

endmodule

`default_nettype wire
